// ===== sv/lcgx_pkg.sv =====
// ----------------------------------------------------------------------------
// lcgx_pkg
// Shared types and constants for the LCG keystream XOR cipher: field widths,
// request codes, generator constants and the precomputed warm-up jump.
// ----------------------------------------------------------------------------
package lcgx_pkg;

  // Field widths.
  localparam int REQ_W   = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 64;
  localparam int STATE_W = 32;
  localparam int SKIP_W  = 4;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_BEGIN    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PASSWORD = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DATA     = 2'd2;

  // Mode register values.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // Generator constants.
  localparam logic [STATE_W-1:0] LCG_MUL  = 32'd1103515245;
  localparam logic [STATE_W-1:0] LCG_INC  = 32'd12345;
  localparam logic [STATE_W-1:0] SEED_MUL = 32'd31;
  localparam int                 WARMUP_STEPS = 16;

  // Length header: eight bytes, little-endian.
  localparam int                HEADER_BYTES = 8;
  localparam logic [SKIP_W-1:0] HEADER_SKIP  = SKIP_W'(HEADER_BYTES);
  localparam int                HDR_CNT_W    = $clog2(HEADER_BYTES);

  // Composes a number of generator steps into one affine map x -> m*x + c,
  // returned as {m, c}. Evaluated only at elaboration.
  function automatic logic [2*STATE_W-1:0] lcg_jump(input int steps);
    logic [STATE_W-1:0] m;
    logic [STATE_W-1:0] c;
    m = 32'd1;
    c = 32'd0;
    for (int i = 0; i < steps; i++) begin
      m = STATE_W'(m * LCG_MUL);
      c = STATE_W'(c * LCG_MUL) + LCG_INC;
    end
    return {m, c};
  endfunction

  // The first data byte runs the warm-up and one more step in a single jump.
  localparam logic [2*STATE_W-1:0] JUMP     = lcg_jump(WARMUP_STEPS + 1);
  localparam logic [STATE_W-1:0]   JUMP_MUL = JUMP[2*STATE_W-1:STATE_W];
  localparam logic [STATE_W-1:0]   JUMP_INC = JUMP[STATE_W-1:0];

endpackage

// ===== sv/lcgx_channels.sv =====
// ----------------------------------------------------------------------------
// lcgx channels
// Valid/ready channel interfaces for requests, result words and the mode
// register write port.
// ----------------------------------------------------------------------------

// Request channel: one request word per handshake.
interface lcgx_req_if;
  logic                           valid;
  logic                           ready;
  logic [lcgx_pkg::REQ_W-1:0]     req_type;
  logic [lcgx_pkg::BYTE_W-1:0]    byte_value;
  logic [lcgx_pkg::LEN_W-1:0]     msg_length;

  modport source (output valid, output req_type, output byte_value,
                  output msg_length, input ready);
  modport sink   (input valid, input req_type, input byte_value,
                  input msg_length, output ready);
endinterface

// Result channel: one output word per handshake.
interface lcgx_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lcgx_pkg::BYTE_W-1:0]    out_byte;
  logic                           is_header;
  logic                           run_last;

  modport source (output valid, output out_byte, output is_header,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input is_header,
                  input run_last, output ready);
endinterface

// Configuration channel: writes the mode register.
interface lcgx_cfg_if;
  logic valid;
  logic ready;
  logic mode;

  modport source (output valid, output mode, input ready);
  modport sink   (input valid, input mode, output ready);
endinterface

// ===== sv/lcg_xor_stream_cipher_unit.sv =====
// ----------------------------------------------------------------------------
// lcg_xor_stream_cipher_unit
// LCG keystream XOR byte cipher with an optional 8-byte length header.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                              Words per item
//   req      in   req_type, byte_value, msg_length     1
//   rsp      out  out_byte, is_header, run_last        0, 1 or 8
//   cfg      in   mode                                 1 (always ready)
//
// A request word is registered in the input register, then processed; a
// data word's result is registered in the result register. One request word
// per cycle is sustained while rsp is ready, except that an encrypt begin
// holds the result register while it shifts out the eight header bytes, so
// the next word that has a result waits for them. The generator update is
// one 32x32 multiply-add per cycle; the warm-up is a precomputed 17-step
// jump. Reset (rst, synchronous) clears the mode, the generator state and
// both valid flags. Stalls on rsp back up into req through the input register.
// ----------------------------------------------------------------------------
module lcg_xor_stream_cipher_unit (
  input  logic              clk,
  input  logic              rst,
  lcgx_req_if.sink          req,
  lcgx_rsp_if.source        rsp,
  lcgx_cfg_if.sink          cfg
);

  // Input register.
  logic                                in_full;
  logic [lcgx_pkg::REQ_W-1:0]          req_type_q;
  logic [lcgx_pkg::BYTE_W-1:0]         byte_q;
  logic [lcgx_pkg::LEN_W-1:0]          len_q;

  // Mode register and cipher state.
  logic                                mode;
  logic [lcgx_pkg::STATE_W-1:0]        ks_state;
  logic [lcgx_pkg::STATE_W-1:0]        ks_state_next;
  logic                                ks_started;
  logic                                ks_started_next;
  logic [lcgx_pkg::SKIP_W-1:0]         skip_cnt;
  logic [lcgx_pkg::SKIP_W-1:0]         skip_cnt_next;

  // Result register and header shifter.
  logic                                out_valid;
  logic [lcgx_pkg::BYTE_W-1:0]         out_byte_r;
  logic                                is_header_r;
  logic                                run_last_r;
  logic [lcgx_pkg::LEN_W-lcgx_pkg::BYTE_W-1:0] hdr_rest;
  logic [lcgx_pkg::HDR_CNT_W-1:0]      hdr_left;

  // Datapath and control.
  logic                                has_result;
  logic                                out_free;
  logic                                proc_fire;
  logic [lcgx_pkg::STATE_W-1:0]        ks_mul;
  logic [lcgx_pkg::STATE_W-1:0]        ks_inc;
  logic [lcgx_pkg::STATE_W-1:0]        ks_adv;
  logic [lcgx_pkg::STATE_W-1:0]        seed_fold;

  // Handshake control: process the held word when its result has room.
  assign has_result = in_full &&
                      ((req_type_q == lcgx_pkg::REQ_BEGIN && mode == lcgx_pkg::MODE_ENCRYPT) ||
                       (req_type_q == lcgx_pkg::REQ_DATA && skip_cnt == '0));
  assign out_free   = !out_valid || (rsp.ready && hdr_left == '0);
  assign proc_fire  = in_full && (!has_result || out_free);
  assign req.ready  = !in_full || proc_fire;
  assign cfg.ready  = 1'b1;

  // Generator step: the first data byte takes the warm-up jump.
  assign ks_mul    = ks_started ? lcgx_pkg::LCG_MUL : lcgx_pkg::JUMP_MUL;
  assign ks_inc    = ks_started ? lcgx_pkg::LCG_INC : lcgx_pkg::JUMP_INC;
  assign ks_adv    = lcgx_pkg::STATE_W'(ks_state * ks_mul) + ks_inc;
  assign seed_fold = lcgx_pkg::STATE_W'(ks_state * lcgx_pkg::SEED_MUL) +
                     lcgx_pkg::STATE_W'(byte_q);

  // Next cipher state for the held request word.
  always_comb begin
    ks_state_next   = ks_state;
    ks_started_next = ks_started;
    skip_cnt_next   = skip_cnt;
    case (req_type_q)
      lcgx_pkg::REQ_BEGIN: begin
        ks_state_next   = '0;
        ks_started_next = 1'b0;
        skip_cnt_next   = (mode == lcgx_pkg::MODE_DECRYPT) ? lcgx_pkg::HEADER_SKIP : '0;
      end
      lcgx_pkg::REQ_PASSWORD: begin
        if (!ks_started) begin
          ks_state_next = seed_fold;
        end
      end
      lcgx_pkg::REQ_DATA: begin
        if (skip_cnt != '0) begin
          skip_cnt_next = skip_cnt - 1'b1;
        end else begin
          ks_state_next   = ks_adv;
          ks_started_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req.ready) begin
      in_full <= req.valid;
    end
    if (req.valid && req.ready) begin
      req_type_q <= req.req_type;
      byte_q     <= req.byte_value;
      len_q      <= req.msg_length;
    end
  end

  // Mode register and cipher state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lcgx_pkg::MODE_ENCRYPT;
      ks_state   <= '0;
      ks_started <= 1'b0;
      skip_cnt   <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        mode <= cfg.mode;
      end
      if (proc_fire) begin
        ks_state   <= ks_state_next;
        ks_started <= ks_started_next;
        skip_cnt   <= skip_cnt_next;
      end
    end
  end

  // Result register: loads a data word or the first header byte, then
  // shifts out the remaining header bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_left  <= '0;
    end else if (proc_fire && has_result) begin
      out_valid <= 1'b1;
      if (req_type_q == lcgx_pkg::REQ_BEGIN) begin
        hdr_left <= lcgx_pkg::HDR_CNT_W'(lcgx_pkg::HEADER_BYTES - 1);
      end else begin
        hdr_left <= '0;
      end
    end else if (out_valid && rsp.ready) begin
      if (hdr_left != '0) begin
        hdr_left <= hdr_left - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && has_result) begin
      if (req_type_q == lcgx_pkg::REQ_BEGIN) begin
        out_byte_r  <= len_q[lcgx_pkg::BYTE_W-1:0];
        is_header_r <= 1'b1;
        run_last_r  <= 1'b0;
        hdr_rest    <= len_q[lcgx_pkg::LEN_W-1:lcgx_pkg::BYTE_W];
      end else begin
        out_byte_r  <= byte_q ^ ks_adv[lcgx_pkg::BYTE_W-1:0];
        is_header_r <= 1'b0;
        run_last_r  <= 1'b1;
      end
    end else if (out_valid && rsp.ready && hdr_left != '0) begin
      out_byte_r <= hdr_rest[lcgx_pkg::BYTE_W-1:0];
      run_last_r <= (hdr_left == lcgx_pkg::HDR_CNT_W'(1));
      hdr_rest   <= {{lcgx_pkg::BYTE_W{1'b0}},
                     hdr_rest[lcgx_pkg::LEN_W-lcgx_pkg::BYTE_W-1:lcgx_pkg::BYTE_W]};
    end
  end

  // Result channel outputs.
  assign rsp.valid     = out_valid;
  assign rsp.out_byte  = out_byte_r;
  assign rsp.is_header = is_header_r;
  assign rsp.run_last  = run_last_r;

endmodule
